// ===== hw/rtl/dsaq_pkg.sv =====
// Shared types, constants and index helpers for the deadline-sorted alarm queue.
package dsaq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;

   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

   localparam int ENTRY_W = 64;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_ADD  = 1'b1;

   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_FIRED    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD_WALK,
      ST_ADD_HEAD,
      ST_TICK_CHECK
   } state_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] delay;
      logic [15:0] tag;
   } entry_type;

   typedef struct packed {
      logic [15:0] delay;
      logic [15:0] tag;
   } pend_type;

   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [15:0]      delay;
      logic [15:0]      tag;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } ram_req_type;

   // a is earlier than b when the wrapped difference is negative
   function automatic logic is_earlier(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   // map a queue position onto a ring slot
   function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + IDX_W'(1);
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/deadline_sorted_alarm_queue.sv =====
// Top level of the deadline-sorted alarm queue: sequencer, entry ring and response register.
//
// Usage:
//   Pulse start with req_type, req_delay_seconds and req_alarm_tag; the word is
//   taken at a rising edge where start is high and busy is low.
//   req_type = add: the alarm goes into the ring in deadline order (newest first
//   among equal deadlines). One response word follows: accepted, or rejected
//   when all entries are in use. An add into an empty or full queue answers
//   straight from idle; otherwise the tail-to-slot walk shifts each entry with
//   a later or equal deadline up one slot, then writes the alarm and answers.
//   The walk runs over the single-read, single-write ring.
//   req_type = tick: the seconds count advances and every due alarm pops from
//   the head, one per cycle (up to 16 words, the final one with rsp_last set).
//   A tick on a non-empty queue holds busy until the head check finds no
//   alarm due; an empty queue leaves busy low. With none due it produces no word.
//   Each response word stands on the rsp_ ports for one cycle, marked by
//   rsp_valid; the receiver must take it then, it cannot stall the block.
//   Reset (synchronous, active high) empties the queue and zeroes the count;
//   the entry RAM keeps no reset value and needs no clearing pass.
module deadline_sorted_alarm_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [15:0] req_delay_seconds,
   input  logic [15:0] req_alarm_tag,
   output logic        rsp_valid,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_fired_delay,
   output logic [15:0] rsp_fired_tag,
   output logic        rsp_last
);

   dsaq_pkg::rsp_type     rsp;
   dsaq_pkg::ram_req_type ram;
   dsaq_pkg::entry_type   ram_rdata;
   logic [dsaq_pkg::ENTRY_W-1:0] rdata_raw;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [15:0] rsp_delay_ff;
   logic [15:0] rsp_tag_ff;
   logic        rsp_last_ff;

   dsaq_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_type          (req_type),
      .req_delay_seconds (req_delay_seconds),
      .req_alarm_tag     (req_alarm_tag),
      .busy              (busy),
      .rsp               (rsp),
      .ram               (ram),
      .ram_rdata         (ram_rdata)
   );

   // ring of stored alarms, one word per slot
   dsaq_entry_ram #(
      .WIDTH  (dsaq_pkg::ENTRY_W),
      .DEPTH  (dsaq_pkg::QUEUE_DEPTH),
      .ADDR_W (dsaq_pkg::IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (ram.we),
      .waddr (ram.waddr),
      .wdata (ram.wdata),
      .raddr (ram.raddr),
      .rdata (rdata_raw)
   );

   assign ram_rdata = dsaq_pkg::entry_type'(rdata_raw);

   // register the response word; strobe clears on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp.kind;
      rsp_delay_ff <= rsp.delay;
      rsp_tag_ff   <= rsp.tag;
      rsp_last_ff  <= rsp.last;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_fired_delay = rsp_delay_ff;
   assign rsp_fired_tag   = rsp_tag_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hw/rtl/dsaq_entry_ram.sv =====
// Simple dual-port entry RAM with registered read data.
module dsaq_entry_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/dsaq_seq.sv =====
// Sequencer: sorted insert walk and due-alarm pop over the entry ring.
module dsaq_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_type,
   input  logic [15:0]          req_delay_seconds,
   input  logic [15:0]          req_alarm_tag,
   output logic                 busy,
   output dsaq_pkg::rsp_type    rsp,
   output dsaq_pkg::ram_req_type ram,
   input  dsaq_pkg::entry_type  ram_rdata
);

   dsaq_pkg::state_type state_ff, state_in;
   logic [dsaq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [31:0]                 now_ff, now_in;
   logic [dsaq_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [dsaq_pkg::IDX_W-1:0]  pos_ff, pos_in;
   dsaq_pkg::entry_type         new_ff, new_in;
   logic [dsaq_pkg::FIRE_W-1:0] fired_ff, fired_in;
   dsaq_pkg::pend_type          pend_ff, pend_in;
   logic                        pend_valid_ff, pend_valid_in;

   logic [dsaq_pkg::CNT_W-1:0]  cnt_m1;
   logic                        due;

   assign cnt_m1 = count_ff - dsaq_pkg::CNT_W'(1);
   assign busy   = (state_ff != dsaq_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dsaq_pkg::ST_IDLE;
         count_ff      <= '0;
         now_ff        <= '0;
         head_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         now_ff        <= now_in;
         head_ff       <= head_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      new_ff   <= new_in;
      fired_ff <= fired_in;
      pend_ff  <= pend_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      now_in        = now_ff;
      head_in       = head_ff;
      pos_in        = pos_ff;
      new_in        = new_ff;
      fired_in      = fired_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      due           = 1'b0;

      ram.we    = 1'b0;
      ram.waddr = head_ff;
      ram.wdata = new_ff;
      ram.raddr = head_ff;

      rsp.valid = 1'b0;
      rsp.kind  = dsaq_pkg::KIND_ACCEPTED;
      rsp.delay = pend_ff.delay;
      rsp.tag   = pend_ff.tag;
      rsp.last  = 1'b0;

      unique case (state_ff)
         dsaq_pkg::ST_IDLE: begin
            if (start) begin
               if (req_type == dsaq_pkg::REQ_ADD) begin
                  rsp.delay = req_delay_seconds;
                  rsp.tag   = req_alarm_tag;
                  if (count_ff == dsaq_pkg::CNT_W'(dsaq_pkg::QUEUE_DEPTH)) begin
                     rsp.valid = 1'b1;
                     rsp.kind  = dsaq_pkg::KIND_REJECTED;
                     rsp.last  = 1'b1;
                  end else begin
                     new_in.deadline = now_ff + {16'b0, req_delay_seconds};
                     new_in.delay    = req_delay_seconds;
                     new_in.tag      = req_alarm_tag;
                     if (count_ff == '0) begin
                        // empty ring: store at the head slot
                        ram.we    = 1'b1;
                        ram.waddr = head_ff;
                        ram.wdata = new_in;
                        count_in  = count_ff + dsaq_pkg::CNT_W'(1);
                        rsp.valid = 1'b1;
                        rsp.last  = 1'b1;
                     end else begin
                        // walk back from the tail
                        pos_in    = cnt_m1[dsaq_pkg::IDX_W-1:0];
                        ram.raddr = dsaq_pkg::phys_addr(head_ff, pos_in);
                        state_in  = dsaq_pkg::ST_ADD_WALK;
                     end
                  end
               end else begin
                  now_in = now_ff + 32'd1;
                  if (count_ff != '0) begin
                     fired_in      = '0;
                     pend_valid_in = 1'b0;
                     ram.raddr     = head_ff;
                     state_in      = dsaq_pkg::ST_TICK_CHECK;
                  end
               end
            end
         end

         dsaq_pkg::ST_ADD_WALK: begin
            ram.we    = 1'b1;
            ram.waddr = dsaq_pkg::phys_addr(head_ff, pos_ff + dsaq_pkg::IDX_W'(1));
            if (dsaq_pkg::is_earlier(ram_rdata.deadline, new_ff.deadline)) begin
               ram.wdata = new_ff;
               count_in  = count_ff + dsaq_pkg::CNT_W'(1);
               rsp.valid = 1'b1;
               rsp.delay = new_ff.delay;
               rsp.tag   = new_ff.tag;
               rsp.last  = 1'b1;
               state_in  = dsaq_pkg::ST_IDLE;
            end else begin
               // shift this entry up one slot
               ram.wdata = ram_rdata;
               if (pos_ff == '0) begin
                  state_in = dsaq_pkg::ST_ADD_HEAD;
               end else begin
                  pos_in    = pos_ff - dsaq_pkg::IDX_W'(1);
                  ram.raddr = dsaq_pkg::phys_addr(head_ff, pos_in);
               end
            end
         end

         dsaq_pkg::ST_ADD_HEAD: begin
            ram.we    = 1'b1;
            ram.waddr = head_ff;
            ram.wdata = new_ff;
            count_in  = count_ff + dsaq_pkg::CNT_W'(1);
            rsp.valid = 1'b1;
            rsp.delay = new_ff.delay;
            rsp.tag   = new_ff.tag;
            rsp.last  = 1'b1;
            state_in  = dsaq_pkg::ST_IDLE;
         end

         dsaq_pkg::ST_TICK_CHECK: begin
            due = (count_ff != '0) &&
                  (fired_ff < dsaq_pkg::FIRE_W'(dsaq_pkg::MAX_RESULTS)) &&
                  !dsaq_pkg::is_earlier(now_ff, ram_rdata.deadline);
            if (due) begin
               // the held word is not last: another alarm follows
               rsp.valid     = pend_valid_ff;
               rsp.kind      = dsaq_pkg::KIND_FIRED;
               pend_in.delay = ram_rdata.delay;
               pend_in.tag   = ram_rdata.tag;
               pend_valid_in = 1'b1;
               head_in       = dsaq_pkg::next_index(head_ff);
               count_in      = count_ff - dsaq_pkg::CNT_W'(1);
               fired_in      = fired_ff + dsaq_pkg::FIRE_W'(1);
               ram.raddr     = head_in;
            end else begin
               rsp.valid     = pend_valid_ff;
               rsp.kind      = dsaq_pkg::KIND_FIRED;
               rsp.last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = dsaq_pkg::ST_IDLE;
            end
         end
      endcase
   end

endmodule
